// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that carries checks.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/btpc_pkg.sv -----
// Package for the barometric compensation block: payload types, sequencer
// codes, register indexes and constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

    localparam int RAW_W      = 20;
    localparam int RAW_BITS_D = 20;
    localparam int W          = 64;

    typedef struct packed {
        logic              kind;
        logic [RAW_W-1:0]  raw_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NO_FT = 2'd1;
    localparam logic [1:0] STAT_DIV0  = 2'd2;

    localparam logic KIND_TEMP = 1'b0;

    localparam logic [2:0] REG_T1 = 3'd0;
    localparam logic [2:0] REG_T2 = 3'd1;
    localparam logic [2:0] REG_T3 = 3'd2;
    localparam logic [2:0] REG_P1 = 3'd3;
    localparam logic [2:0] REG_PA = 3'd4;
    localparam logic [2:0] REG_PB = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        ST_T_A, ST_T_D, ST_T_3,
        ST_P_SQ, ST_P_6, ST_P_5, ST_P_3, ST_P_2, ST_P_1,
        ST_P_N, ST_P_DIV, ST_P_9A, ST_P_9B, ST_P_8
    } t_step;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_au_req;

    function automatic logic [W-1:0] sx16(input logic [15:0] v);
        return {{(W-16){v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/btpc_serial_au.sv -----
// Bit-serial 64-bit arithmetic unit: wrapping multiply and signed divide,
// one bit per cycle. Depends on btpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btpc_serial_au (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire btpc_pkg::t_au_req    i_req,
    input  wire logic [63:0]          i_op_a,
    input  wire logic [63:0]          i_op_b,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [63:0]               o_result
);
    import btpc_pkg::*;

    logic        r_busy, r_done, r_div, r_neg;
    logic [6:0]  r_cnt;
    logic [63:0] r_acc, r_a, r_b, r_res;
    logic [64:0] w_rem_sh, w_diff;

    // Restoring division keeps the partial remainder in r_acc and shifts the
    // quotient into r_a as the dividend leaves it.
    assign w_rem_sh = {r_acc, r_a[63]};
    assign w_diff   = w_rem_sh - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt[6]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_cnt <= '0;
            r_acc <= '0;
            r_div <= i_req.is_div;
            r_neg <= i_req.is_div & (i_op_a[63] ^ i_op_b[63]);
            r_a   <= (i_req.is_div && i_op_a[63]) ? -i_op_a : i_op_a;
            r_b   <= (i_req.is_div && i_op_b[63]) ? -i_op_b : i_op_b;
        end else if (r_busy && !r_cnt[6]) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_div) begin
                if (!w_diff[64]) begin
                    r_acc <= w_diff[63:0];
                end else begin
                    r_acc <= w_rem_sh[63:0];
                end
                r_a <= {r_a[62:0], ~w_diff[64]};
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[62:0], 1'b0};
                r_b <= {1'b0, r_b[63:1]};
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_res <= r_neg ? -r_a : r_a;
            end else begin
                r_res <= r_acc;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ----- rtl/barometer_temp_pressure_compensation.sv -----
// A temperature transfer runs three serial multiplies, and a pressure transfer ten serial
// multiplies and one serial divide, before the result is loaded into the output register;
// a zero divisor ends after six steps, and a pressure transfer without a fine temperature
// goes straight to the output. One item at a time, set by the single bit-serial arithmetic
// unit: a new item is taken only once the last result is in the output register, later
// while a result waits to leave.
// Reset (synchronous, active low) clears calibration, fine temperature and control.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module barometer_temp_pressure_compensation #(
    parameter int RAW_BITS = btpc_pkg::RAW_BITS_D
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire btpc_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output btpc_pkg::t_out       o_out_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [5:0]      paddr,
    input  wire logic [63:0]     pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import btpc_pkg::*;

    // Calibration registers, each 8 bytes apart on the configuration port.
    logic [15:0] r_t1, r_t2, r_t3, r_p1;
    logic [63:0] r_pa, r_pb;
    logic [2:0]  w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_p1 <= '0;
            r_pa <= '0;
            r_pb <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_T1:  r_t1 <= pwdata[15:0];
                REG_T2:  r_t2 <= pwdata[15:0];
                REG_T3:  r_t3 <= pwdata[15:0];
                REG_P1:  r_p1 <= pwdata[15:0];
                REG_PA:  r_pa <= pwdata;
                REG_PB:  r_pb <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_T1:  prdata = {48'd0, r_t1};
            REG_T2:  prdata = {48'd0, r_t2};
            REG_T3:  prdata = {48'd0, r_t3};
            REG_P1:  prdata = {48'd0, r_p1};
            REG_PA:  prdata = r_pa;
            REG_PB:  prdata = r_pb;
            default: prdata = '0;
        endcase
    end

    // Coefficients widened to 64 bits: T1 and P1 zero-extended, the rest sign-extended.
    // Pressure coefficients two to nine are packed four to a 64-bit register, lowest first.
    logic [63:0] w_t1, w_t2, w_t3, w_p1;
    logic [63:0] w_c2, w_c3, w_c4, w_c5, w_c6, w_c7, w_c8, w_c9;

    assign w_t1 = {48'd0, r_t1};
    assign w_t2 = sx16(r_t2);
    assign w_t3 = sx16(r_t3);
    assign w_p1 = {48'd0, r_p1};
    assign w_c2 = sx16(r_pa[15:0]);
    assign w_c3 = sx16(r_pa[31:16]);
    assign w_c4 = sx16(r_pa[47:32]);
    assign w_c5 = sx16(r_pa[63:48]);
    assign w_c6 = sx16(r_pb[15:0]);
    assign w_c7 = sx16(r_pb[31:16]);
    assign w_c8 = sx16(r_pb[47:32]);
    assign w_c9 = sx16(r_pb[63:48]);

    // The sequencer walks a fixed list of steps. Each step hands one multiply
    // or divide to the serial unit and folds the product back into the working
    // registers, so wide arithmetic between registers stays a short chain of adds.
    t_state      r_state, n_state;
    t_step       r_step, n_step;
    logic [63:0] r_raw, n_raw;
    logic [63:0] r_v1, n_v1, r_v2, n_v2, r_m, n_m, r_p, n_p;
    logic [31:0] r_ft, n_ft;
    logic [31:0] r_val, n_val;
    logic [1:0]  r_stat, n_stat;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    t_au_req     w_req;
    logic        w_start, w_is_div;
    logic [63:0] w_op_a, w_op_b, w_res;
    logic        w_au_done, w_au_busy;

    logic [63:0] w_raw_in, w_ftx, w_tv1, w_tv2, w_tf, w_tval;
    logic [63:0] w_pv2, w_psum, w_ps, w_pt, w_pq;
    logic        w_accept;

    assign w_accept = i_in_valid && o_in_ready;
    // Readings narrower than 20 bits are moved up onto the 20-bit scale.
    assign w_raw_in = 64'(i_in_data.raw_value[RAW_BITS-1:0]) << (RAW_W - RAW_BITS);
    assign w_ftx    = {{32{r_ft[31]}}, r_ft};
    assign w_pq     = 64'($signed(r_p) >>> 13);
    assign w_req    = '{start: w_start, is_div: w_is_div};

    btpc_serial_au u_au (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_op_a   (w_op_a),
        .i_op_b   (w_op_b),
        .o_busy   (w_au_busy),
        .o_done   (w_au_done),
        .o_result (w_res)
    );

    // Operand selection for the step being issued.
    always_comb begin
        w_is_div = 1'b0;
        unique case (r_step)
            ST_T_A: begin
                w_op_a = (r_raw >> 3) - (w_t1 << 1);
                w_op_b = w_t2;
            end
            ST_T_D: begin
                w_op_a = (r_raw >> 4) - w_t1;
                w_op_b = (r_raw >> 4) - w_t1;
            end
            ST_T_3: begin
                w_op_a = r_v2;
                w_op_b = w_t3;
            end
            ST_P_SQ: begin
                w_op_a = r_v1;
                w_op_b = r_v1;
            end
            ST_P_6: begin
                w_op_a = r_m;
                w_op_b = w_c6;
            end
            ST_P_5: begin
                w_op_a = r_v1;
                w_op_b = w_c5;
            end
            ST_P_3: begin
                w_op_a = r_m;
                w_op_b = w_c3;
            end
            ST_P_2: begin
                w_op_a = r_v1;
                w_op_b = w_c2;
            end
            ST_P_1: begin
                w_op_a = (64'd1 << 47) + r_v1;
                w_op_b = w_p1;
            end
            ST_P_N: begin
                w_op_a = (((64'd1 << 20) - r_raw) << 31) - r_v2;
                w_op_b = 64'd3125;
            end
            ST_P_DIV: begin
                w_op_a   = r_m;
                w_op_b   = r_v1;
                w_is_div = 1'b1;
            end
            ST_P_9A: begin
                w_op_a = w_c9;
                w_op_b = w_pq;
            end
            ST_P_9B: begin
                w_op_a = r_m;
                w_op_b = w_pq;
            end
            ST_P_8: begin
                w_op_a = w_c8;
                w_op_b = r_p;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Final temperature: fine temperature, then (5 * t + 128) >> 8.
    assign w_tv2  = 64'($signed(w_res) >>> 14);
    assign w_tv1  = r_v1 + w_tv2;
    assign w_tf   = {{32{w_tv1[31]}}, w_tv1[31:0]};
    assign w_tval = 64'($signed((w_tf << 2) + w_tf + 64'd128) >>> 8);

    // Final pressure: the 32.8 result, then a divide by 256 toward zero,
    // which for a negative value is a bias of 255 before the shift.
    assign w_pv2  = 64'($signed(w_res) >>> 19);
    assign w_psum = r_p + r_v1 + w_pv2;
    assign w_ps   = 64'($signed(w_psum) >>> 8) + (w_c7 << 4);
    assign w_pt   = w_ps[63] ? (w_ps + 64'd255) : w_ps;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_raw       = r_raw;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_m         = r_m;
        n_p         = r_p;
        n_ft        = r_ft;
        n_val       = r_val;
        n_stat      = r_stat;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_start     = 1'b0;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_raw  = w_raw_in;
                    n_stat = STAT_OK;
                    if (i_in_data.kind == KIND_TEMP) begin
                        n_step  = ST_T_A;
                        n_state = S_ISSUE;
                    end else if (r_ft == '0) begin
                        n_val   = '0;
                        n_stat  = STAT_NO_FT;
                        n_state = S_FINISH;
                    end else begin
                        n_v1    = w_ftx - 64'd128000;
                        n_step  = ST_P_SQ;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                w_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_au_done) begin
                    n_state = S_ISSUE;
                    n_step  = t_step'(r_step + 4'd1);
                    unique case (r_step)
                        ST_T_A:   n_v1 = 64'($signed(w_res) >>> 11);
                        ST_T_D:   n_v2 = 64'($signed(w_res) >>> 12);
                        ST_T_3: begin
                            n_ft    = w_tv1[31:0];
                            n_val   = w_tval[31:0];
                            n_state = S_FINISH;
                        end
                        ST_P_SQ:  n_m  = w_res;
                        ST_P_6:   n_v2 = w_res;
                        ST_P_5:   n_v2 = r_v2 + (w_res << 17) + (w_c4 << 35);
                        ST_P_3:   n_m  = 64'($signed(w_res) >>> 8);
                        ST_P_2:   n_v1 = r_m + (w_res << 12);
                        ST_P_1: begin
                            n_v1 = 64'($signed(w_res) >>> 33);
                            if (n_v1 == '0) begin
                                n_val   = '0;
                                n_stat  = STAT_DIV0;
                                n_step  = r_step;
                                n_state = S_FINISH;
                            end
                        end
                        ST_P_N:   n_m  = w_res;
                        ST_P_DIV: n_p  = w_res;
                        ST_P_9A:  n_m  = w_res;
                        ST_P_9B:  n_v1 = 64'($signed(w_res) >>> 25);
                        ST_P_8: begin
                            n_val   = w_pt[39:8];
                            n_state = S_FINISH;
                        end
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_FINISH: begin
                // Wait for the output register to be free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.value  = r_val;
                    n_out.status = r_stat;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_T_A;
            r_ft        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_ft        <= n_ft;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_v1   <= n_v1;
        r_v2   <= n_v2;
        r_m    <= n_m;
        r_p    <= n_p;
        r_val  <= n_val;
        r_stat <= n_stat;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted transfer always leaves the idle state on the next edge.
    `ASSERT_CLKD(a_accept_leaves_idle, (i_in_valid && o_in_ready) |=> (r_state != S_IDLE), "accepted transfer did not start work")
    // The arithmetic unit never runs while the sequencer is idle.
    `ASSERT_CLKD(a_au_idle, (r_state == S_IDLE) |-> !w_au_busy, "arithmetic unit busy while idle")
    // A result never carries an undefined status code.
    `ASSERT_CLKD(a_status_code, o_out_valid |-> (o_out_data.status != 2'd3), "undefined status on output")
    // A zero-divisor result only follows the scale step.
    `ASSERT_CLKD(a_div0_origin, ((r_state == S_FINISH) && (r_stat == STAT_DIV0)) |-> (r_step == ST_P_1), "zero divisor reported from wrong step")

endmodule
`default_nettype wire
